// ===== src/ppes_pkg.sv =====
// Shared types, codes and widths of the priority periodic event scheduler.
package ppes_pkg;

    localparam int OP_W     = 2;
    localparam int LEVEL_W  = 3;
    localparam int CB_W     = 8;
    localparam int WORD_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_SCHED   = 2'd0,
        OP_SVC_ONE = 2'd1,
        OP_SVC_ALL = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_REPLY = 2'd0,
        KIND_FIRE  = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Which response the datapath loads into its output register
    typedef enum logic [2:0] {
        RES_SCHED_OK,
        RES_BAD,
        RES_FULL,
        RES_DONE_OK,
        RES_DONE_BAD,
        RES_CLEAR,
        RES_FIRE
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_READ,
        S_EVAL,
        S_FINAL
    } t_state;

    // One table entry
    typedef struct packed {
        logic [CB_W-1:0]   callback;
        logic [WORD_W-1:0] arg;
        logic [WORD_W-1:0] period;
        logic [WORD_W-1:0] runs_left;
        logic [WORD_W-1:0] due;
    } t_entry;

    // Latched request
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [LEVEL_W-1:0] level;
        logic [CB_W-1:0]    callback_id;
        logic [WORD_W-1:0]  callback_arg;
        logic [WORD_W-1:0]  period;
        logic [WORD_W-1:0]  run_count;
        logic [WORD_W-1:0]  now;
    } t_req;

    // Response payload
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  out_level;
        logic [SLOT_W-1:0]   slot;
        logic [CB_W-1:0]     fired_callback;
        logic [WORD_W-1:0]   fired_arg;
        logic                final_run;
        logic                last;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the incoming request
        logic init;      // set the slot counters to the start of the sweep
        logic init_all;  // start at level 0 instead of the requested level
        logic step;      // advance to the next slot
        logic push;      // load a response into the output register
        t_res res;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic sched_bad;
        logic lvl_bad;
        logic enabled;
        logic no_slots;
        logic cur_active;
        logic fire;
        logic j_last;
        logic lvl_last;
        logic out_free;
    } t_sts;

endpackage

// ===== src/ppes_if.sv =====
// Request and response channel interfaces of the event scheduler.
interface ppes_req_if;
    logic                              valid;
    logic                              ready;
    logic [ppes_pkg::OP_W-1:0]         op;
    logic [ppes_pkg::LEVEL_W-1:0]      level;
    logic [ppes_pkg::CB_W-1:0]         callback_id;
    logic [ppes_pkg::WORD_W-1:0]       callback_arg;
    logic [ppes_pkg::WORD_W-1:0]       period;
    logic [ppes_pkg::WORD_W-1:0]       run_count;
    logic [ppes_pkg::WORD_W-1:0]       now;

    modport source (
        output valid, op, level, callback_id, callback_arg, period, run_count, now,
        input  ready
    );
    modport sink (
        input  valid, op, level, callback_id, callback_arg, period, run_count, now,
        output ready
    );
endinterface

interface ppes_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [ppes_pkg::KIND_W-1:0]       kind;
    logic [ppes_pkg::STATUS_W-1:0]     status;
    logic [ppes_pkg::LEVEL_W-1:0]      out_level;
    logic [ppes_pkg::SLOT_W-1:0]       slot;
    logic [ppes_pkg::CB_W-1:0]         fired_callback;
    logic [ppes_pkg::WORD_W-1:0]       fired_arg;
    logic                              final_run;
    logic                              last;

    modport source (
        output valid, kind, status, out_level, slot, fired_callback, fired_arg,
               final_run, last,
        input  ready
    );
    modport sink (
        input  valid, kind, status, out_level, slot, fired_callback, fired_arg,
               final_run, last,
        output ready
    );
endinterface

// ===== src/priority_periodic_event_scheduler_unit.sv =====
// Top level of the priority periodic event scheduler.
//
// Requests arrive on i_req (valid/ready); op selects schedule, service one
// level, service all levels or clear. Responses leave on o_rsp (valid/ready);
// each request yields one or more responses and the last carries last = 1.
// Schedule and clear give a single reply; a service sweep gives one fired
// response per due event, then a done response.
// Timing: a request is taken in the idle state and decoded in the next cycle. Clear
// and schedules with bad parameters go from decode straight to the final reply. Any
// other schedule searches the level one slot per cycle. A sweep reads the slot
// table through its single registered port, with a read state and then an
// evaluate state for each slot, over one level or over all levels.
// One request is in work at a time; the next is taken once the final
// response is in the output register, even while that response waits.
// Reset empties the table, disables the block and drops any pending
// response; no clearing pass is needed. A stalled receiver holds the output
// register and the sweep waits at the next firing until it drains.
module priority_periodic_event_scheduler_unit #(
    parameter int LEVELS      = 4,
    parameter int TOTAL_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppes_req_if.sink   i_req,
    ppes_rsp_if.source o_rsp
);

    ppes_pkg::t_req  req;
    ppes_pkg::t_cmd  cmd;
    ppes_pkg::t_sts  sts;
    ppes_pkg::t_rsp  rsp;
    logic            req_ready;
    logic            rsp_valid;

    // Gather the request payload
    always_comb begin
        req.op           = i_req.op;
        req.level        = i_req.level;
        req.callback_id  = i_req.callback_id;
        req.callback_arg = i_req.callback_arg;
        req.period       = i_req.period;
        req.run_count    = i_req.run_count;
        req.now          = i_req.now;
    end

    ppes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    ppes_dp #(
        .LEVELS      (LEVELS),
        .TOTAL_SLOTS (TOTAL_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_cmd       (cmd),
        .i_out_ready (o_rsp.ready),
        .o_sts       (sts),
        .o_out_valid (rsp_valid),
        .o_out       (rsp)
    );

    // Channel outputs
    assign i_req.ready          = req_ready;
    assign o_rsp.valid          = rsp_valid;
    assign o_rsp.kind           = rsp.kind;
    assign o_rsp.status         = rsp.status;
    assign o_rsp.out_level      = rsp.out_level;
    assign o_rsp.slot           = rsp.slot;
    assign o_rsp.fired_callback = rsp.fired_callback;
    assign o_rsp.fired_arg      = rsp.fired_arg;
    assign o_rsp.final_run      = rsp.final_run;
    assign o_rsp.last           = rsp.last;

endmodule

// ===== src/ppes_dp.sv =====
// Scheduler datapath: request register, slot table, counters and output register.
module ppes_dp #(
    parameter int LEVELS      = 4,
    parameter int TOTAL_SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppes_pkg::t_req                i_req,
    input  ppes_pkg::t_cmd                i_cmd,
    input  logic                          i_out_ready,
    output ppes_pkg::t_sts                o_sts,
    output logic                          o_out_valid,
    output ppes_pkg::t_rsp                o_out
);

    localparam int PER_LEVEL = TOTAL_SLOTS / LEVELS;
    localparam int ADDR_W    = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int J_W       = (PER_LEVEL > 1) ? $clog2(PER_LEVEL) : 1;

    ppes_pkg::t_req                r_req;
    ppes_pkg::t_entry              r_mem [TOTAL_SLOTS];
    ppes_pkg::t_entry              r_q;
    ppes_pkg::t_entry              wdata;
    logic                          we;
    logic [TOTAL_SLOTS-1:0]        r_active;
    logic                          r_enabled;
    logic [ADDR_W-1:0]             r_addr;
    logic [J_W-1:0]                r_j;
    logic [ppes_pkg::LEVEL_W-1:0]  r_lvl;
    logic                          r_out_valid;
    ppes_pkg::t_rsp                r_out;
    ppes_pkg::t_rsp                n_out;
    logic                          out_free;
    logic                          cur_active;
    logic                          lvl_bad;
    logic [J_W+ppes_pkg::SLOT_W-1:0] j_ext;
    logic [ppes_pkg::WORD_W-1:0]   runs_next;

    // Request register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    // Slot counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_j <= '0;
            if (i_cmd.init_all) begin
                r_lvl  <= '0;
                r_addr <= '0;
            end else begin
                r_lvl  <= r_req.level;
                r_addr <= ADDR_W'(int'(r_req.level) * PER_LEVEL);
            end
        end else if (i_cmd.step) begin
            r_addr <= ADDR_W'(r_addr + 1'b1);
            if (r_j == J_W'(PER_LEVEL - 1)) begin
                r_j   <= '0;
                r_lvl <= ppes_pkg::LEVEL_W'(r_lvl + 1'b1);
            end else begin
                r_j <= J_W'(r_j + 1'b1);
            end
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign cur_active = r_active[r_addr];
    assign lvl_bad    = {1'b0, r_req.level} >= (ppes_pkg::LEVEL_W + 1)'(LEVELS);
    assign j_ext      = {{ppes_pkg::SLOT_W{1'b0}}, r_j};
    assign runs_next  = (r_q.runs_left > 32'd1) ? r_q.runs_left - 32'd1 : r_q.runs_left;

    // Table write: new entry on schedule, updated count and due time on a firing
    always_comb begin
        we    = i_cmd.push && (i_cmd.res == ppes_pkg::RES_SCHED_OK
                            || i_cmd.res == ppes_pkg::RES_FIRE);
        wdata = r_q;
        if (i_cmd.res == ppes_pkg::RES_SCHED_OK) begin
            wdata.callback  = r_req.callback_id;
            wdata.arg       = r_req.callback_arg;
            wdata.period    = r_req.period;
            wdata.runs_left = r_req.run_count;
            wdata.due       = r_req.now + r_req.period;
        end else begin
            wdata.runs_left = runs_next;
            wdata.due       = r_q.due + r_q.period;
        end
    end

    // Slot table memory with registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_addr] <= wdata;
        end
        r_q <= r_mem[r_addr];
    end

    // Active bits and enable flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_enabled <= 1'b0;
        end else if (i_cmd.push) begin
            case (i_cmd.res)
                ppes_pkg::RES_SCHED_OK: begin
                    r_active[r_addr] <= 1'b1;
                    r_enabled        <= 1'b1;
                end
                ppes_pkg::RES_FIRE: begin
                    if (r_q.runs_left == 32'd1) begin
                        r_active[r_addr] <= 1'b0;
                    end
                end
                ppes_pkg::RES_CLEAR: begin
                    r_active  <= '0;
                    r_enabled <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Response payload
    always_comb begin
        n_out      = '0;
        n_out.last = 1'b1;
        case (i_cmd.res)
            ppes_pkg::RES_SCHED_OK: begin
                n_out.kind      = ppes_pkg::KIND_REPLY;
                n_out.status    = ppes_pkg::ST_OK;
                n_out.out_level = r_lvl;
                n_out.slot      = j_ext[ppes_pkg::SLOT_W-1:0];
            end
            ppes_pkg::RES_BAD: begin
                n_out.kind   = ppes_pkg::KIND_REPLY;
                n_out.status = ppes_pkg::ST_BAD;
            end
            ppes_pkg::RES_FULL: begin
                n_out.kind   = ppes_pkg::KIND_REPLY;
                n_out.status = ppes_pkg::ST_FULL;
            end
            ppes_pkg::RES_DONE_OK: begin
                n_out.kind   = ppes_pkg::KIND_DONE;
                n_out.status = ppes_pkg::ST_OK;
            end
            ppes_pkg::RES_DONE_BAD: begin
                n_out.kind   = ppes_pkg::KIND_DONE;
                n_out.status = ppes_pkg::ST_BAD;
            end
            ppes_pkg::RES_CLEAR: begin
                n_out.kind = ppes_pkg::KIND_REPLY;
            end
            ppes_pkg::RES_FIRE: begin
                n_out.kind           = ppes_pkg::KIND_FIRE;
                n_out.status         = ppes_pkg::ST_OK;
                n_out.out_level      = r_lvl;
                n_out.slot           = j_ext[ppes_pkg::SLOT_W-1:0];
                n_out.fired_callback = r_q.callback;
                n_out.fired_arg      = r_q.arg;
                n_out.final_run      = (r_q.runs_left == 32'd1);
                n_out.last           = 1'b0;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status to the controller
    always_comb begin
        o_sts            = '0;
        o_sts.op         = ppes_pkg::t_op'(r_req.op);
        o_sts.lvl_bad    = lvl_bad;
        o_sts.sched_bad  = lvl_bad || (r_req.callback_id == '0) || (r_req.period == '0);
        o_sts.enabled    = r_enabled;
        o_sts.no_slots   = (PER_LEVEL == 0);
        o_sts.cur_active = cur_active;
        o_sts.fire       = cur_active && (r_q.due <= r_req.now);
        o_sts.j_last     = (r_j == J_W'(PER_LEVEL - 1));
        o_sts.lvl_last   = (r_lvl == ppes_pkg::LEVEL_W'(LEVELS - 1));
        o_sts.out_free   = out_free;
    end

`ifndef SYNTHESIS
    // A response is only loaded when the output register can take it
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> out_free)
        else $error("response loaded over an unread response");

    // A firing always comes from an active slot
    a_fire_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && i_cmd.res == ppes_pkg::RES_FIRE) |-> cur_active)
        else $error("inactive slot fired");

    // Clear empties the table and disables the block
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && i_cmd.res == ppes_pkg::RES_CLEAR) |=> (r_active == '0 && !r_enabled))
        else $error("table not empty after clear");

    // A slot is only assigned when it is free
    a_sched_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && i_cmd.res == ppes_pkg::RES_SCHED_OK) |-> !cur_active)
        else $error("busy slot assigned");

    // Any active slot implies the block is enabled
    a_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active != '0) |-> r_enabled)
        else $error("active slot while disabled");
`endif

endmodule

// ===== src/ppes_ctrl.sv =====
// Scheduler controller: sequences decode, free-slot search and service sweeps.
module ppes_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  ppes_pkg::t_sts  i_sts,
    output logic            o_req_ready,
    output ppes_pkg::t_cmd  o_cmd
);

    ppes_pkg::t_state r_state;
    ppes_pkg::t_state n_state;
    ppes_pkg::t_res   r_res;
    ppes_pkg::t_res   n_res;
    logic             sweep_end;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppes_pkg::S_IDLE;
            r_res   <= ppes_pkg::RES_DONE_OK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    // Last slot of the sweep: end of the level, or of the last level for all
    assign sweep_end = i_sts.j_last && (i_sts.op != ppes_pkg::OP_SVC_ALL || i_sts.lvl_last);

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        o_cmd.res   = r_res;
        unique case (r_state)
            ppes_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ppes_pkg::S_DECODE;
                end
            end
            ppes_pkg::S_DECODE: begin
                n_state = ppes_pkg::S_FINAL;
                unique case (i_sts.op)
                    ppes_pkg::OP_SCHED: begin
                        if (i_sts.sched_bad) begin
                            n_res = ppes_pkg::RES_BAD;
                        end else if (i_sts.no_slots) begin
                            n_res = ppes_pkg::RES_FULL;
                        end else begin
                            o_cmd.init = 1'b1;
                            n_state    = ppes_pkg::S_FIND;
                        end
                    end
                    ppes_pkg::OP_SVC_ONE: begin
                        if (i_sts.lvl_bad) begin
                            n_res = ppes_pkg::RES_DONE_BAD;
                        end else if (!i_sts.enabled || i_sts.no_slots) begin
                            n_res = ppes_pkg::RES_DONE_OK;
                        end else begin
                            o_cmd.init = 1'b1;
                            n_state    = ppes_pkg::S_READ;
                        end
                    end
                    ppes_pkg::OP_SVC_ALL: begin
                        if (!i_sts.enabled || i_sts.no_slots) begin
                            n_res = ppes_pkg::RES_DONE_OK;
                        end else begin
                            o_cmd.init     = 1'b1;
                            o_cmd.init_all = 1'b1;
                            n_state        = ppes_pkg::S_READ;
                        end
                    end
                    ppes_pkg::OP_CLEAR: begin
                        n_res = ppes_pkg::RES_CLEAR;
                    end
                    default: ;
                endcase
            end
            // Search the level for its first free slot
            ppes_pkg::S_FIND: begin
                if (!i_sts.cur_active) begin
                    n_res   = ppes_pkg::RES_SCHED_OK;
                    n_state = ppes_pkg::S_FINAL;
                end else if (i_sts.j_last) begin
                    n_res   = ppes_pkg::RES_FULL;
                    n_state = ppes_pkg::S_FINAL;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            // Table read in flight
            ppes_pkg::S_READ: begin
                n_state = ppes_pkg::S_EVAL;
            end
            // Fire the slot if due, then move on
            ppes_pkg::S_EVAL: begin
                if (!i_sts.fire || i_sts.out_free) begin
                    if (i_sts.fire) begin
                        o_cmd.push = 1'b1;
                        o_cmd.res  = ppes_pkg::RES_FIRE;
                    end
                    if (sweep_end) begin
                        n_res   = ppes_pkg::RES_DONE_OK;
                        n_state = ppes_pkg::S_FINAL;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = ppes_pkg::S_READ;
                    end
                end
            end
            // Final response of the request
            ppes_pkg::S_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ppes_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppes_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the priority periodic event scheduler.
`timescale 1ns / 100ps

module testbench;

    localparam int LEVELS       = 4;
    localparam int TOTAL_SLOTS  = 16;
    localparam int PER_LEVEL    = TOTAL_SLOTS / LEVELS;
    localparam int RANDOM_ITEMS = 350;
    localparam int QUIET_ITEMS  = 60;
    localparam int HOLD_AT      = 150;
    localparam int DRAIN_AT     = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 500000;

    // Mirror of the event table; predicts the responses of every request
    class sched_table_model;
        bit              active    [TOTAL_SLOTS];
        bit [7:0]        callback  [TOTAL_SLOTS];
        bit [31:0]       arg       [TOTAL_SLOTS];
        bit [31:0]       period    [TOTAL_SLOTS];
        bit [31:0]       runs_left [TOTAL_SLOTS];
        bit [31:0]       due       [TOTAL_SLOTS];
        int              occupancy [LEVELS];
        bit              enabled;
        ppes_pkg::t_rsp  expected_rsp[$];
        int              mismatches;

        function new();
            mismatches = 0;
            empty_table();
        endfunction

        function void empty_table();
            foreach (active[s]) active[s] = 1'b0;
            foreach (occupancy[l]) occupancy[l] = 0;
            enabled = 1'b0;
        endfunction

        // Fired responses are never last; every reply and done item closes a request
        function void add_expected(ppes_pkg::t_kind kind, ppes_pkg::t_status st,
                                   int lvl, int slot,
                                   bit [7:0] cb, bit [31:0] cb_arg, bit fin);
            ppes_pkg::t_rsp r;
            r.kind           = kind;
            r.status         = st;
            r.out_level      = 3'(lvl);
            r.slot           = 4'(slot);
            r.fired_callback = cb;
            r.fired_arg      = cb_arg;
            r.final_run      = fin;
            r.last           = (kind != ppes_pkg::KIND_FIRE);
            expected_rsp.push_back(r);
        endfunction

        // Fire every due slot of one level in index order
        function void sweep_level(int lvl, bit [31:0] now);
            int s;
            bit fin;
            if (occupancy[lvl] == 0) return;
            for (int j = 0; j < PER_LEVEL; j++) begin
                s = lvl * PER_LEVEL + j;
                if (!active[s] || due[s] > now) continue;
                fin = 1'b0;
                if (runs_left[s] == 1) begin
                    active[s] = 1'b0;
                    if (occupancy[lvl] > 0) occupancy[lvl]--;
                    fin = 1'b1;
                end else if (runs_left[s] > 1) begin
                    runs_left[s]--;
                end
                add_expected(ppes_pkg::KIND_FIRE, ppes_pkg::ST_OK, lvl, j,
                             callback[s], arg[s], fin);
                due[s] = due[s] + period[s];
            end
        endfunction

        function void note_request(ppes_pkg::t_req r);
            int lvl;
            int s;
            bit placed;
            lvl = int'(r.level);
            case (r.op)
                ppes_pkg::OP_SCHED: begin
                    if (lvl >= LEVELS || r.callback_id == 0 || r.period == 0) begin
                        add_expected(ppes_pkg::KIND_REPLY, ppes_pkg::ST_BAD, 0, 0, 0, 0, 0);
                    end else if (occupancy[lvl] >= PER_LEVEL) begin
                        add_expected(ppes_pkg::KIND_REPLY, ppes_pkg::ST_FULL, 0, 0, 0, 0, 0);
                    end else begin
                        placed = 1'b0;
                        for (int j = 0; j < PER_LEVEL; j++) begin
                            s = lvl * PER_LEVEL + j;
                            if (!placed && !active[s]) begin
                                callback[s]  = r.callback_id;
                                arg[s]       = r.callback_arg;
                                period[s]    = r.period;
                                runs_left[s] = r.run_count;
                                due[s]       = r.now + r.period;
                                active[s]    = 1'b1;
                                occupancy[lvl]++;
                                enabled      = 1'b1;
                                placed       = 1'b1;
                                add_expected(ppes_pkg::KIND_REPLY, ppes_pkg::ST_OK,
                                             lvl, j, 0, 0, 0);
                            end
                        end
                        if (!placed)
                            add_expected(ppes_pkg::KIND_REPLY, ppes_pkg::ST_FULL,
                                         0, 0, 0, 0, 0);
                    end
                end
                ppes_pkg::OP_SVC_ONE: begin
                    if (lvl >= LEVELS) begin
                        add_expected(ppes_pkg::KIND_DONE, ppes_pkg::ST_BAD, 0, 0, 0, 0, 0);
                    end else begin
                        if (enabled) sweep_level(lvl, r.now);
                        add_expected(ppes_pkg::KIND_DONE, ppes_pkg::ST_OK, 0, 0, 0, 0, 0);
                    end
                end
                ppes_pkg::OP_SVC_ALL: begin
                    if (enabled)
                        for (int l = 0; l < LEVELS; l++) sweep_level(l, r.now);
                    add_expected(ppes_pkg::KIND_DONE, ppes_pkg::ST_OK, 0, 0, 0, 0, 0);
                end
                default: begin
                    empty_table();
                    add_expected(ppes_pkg::KIND_REPLY, ppes_pkg::ST_OK, 0, 0, 0, 0, 0);
                end
            endcase
        endfunction

        function void compare_field(string field, bit [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_response(ppes_pkg::t_rsp got);
            ppes_pkg::t_rsp want;
            if (expected_rsp.size() == 0) begin
                mismatches++;
                $display("%0t: response with nothing expected, expected none, actual %0h",
                         $time, got);
                return;
            end
            want = expected_rsp.pop_front();
            compare_field("kind",           32'(want.kind),           32'(got.kind));
            compare_field("status",         32'(want.status),         32'(got.status));
            compare_field("out_level",      32'(want.out_level),      32'(got.out_level));
            compare_field("slot",           32'(want.slot),           32'(got.slot));
            compare_field("fired_callback", 32'(want.fired_callback), 32'(got.fired_callback));
            compare_field("fired_arg",      want.fired_arg,           got.fired_arg);
            compare_field("final_run",      32'(want.final_run),      32'(got.final_run));
            compare_field("last",           32'(want.last),           32'(got.last));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ppes_req_if req_if();
    ppes_rsp_if rsp_if();

    sched_table_model sched_sb = new();

    int        idle_pct;
    bit        hold_off_req;
    int        cycle_count;
    bit [31:0] tick_now;

    priority_periodic_event_scheduler_unit #(
        .LEVELS      (LEVELS),
        .TOTAL_SLOTS (TOTAL_SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Response side: random stall bursts, plus one long hold-off on request
    initial begin : rsp_ready_drive
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rsp_if.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < idle_pct / 3) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Response monitor
    always @(posedge i_clk) begin
        ppes_pkg::t_rsp got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.kind           = rsp_if.kind;
            got.status         = rsp_if.status;
            got.out_level      = rsp_if.out_level;
            got.slot           = rsp_if.slot;
            got.fired_callback = rsp_if.fired_callback;
            got.fired_arg      = rsp_if.fired_arg;
            got.final_run      = rsp_if.final_run;
            got.last           = rsp_if.last;
            sched_sb.check_response(got);
        end
    end

    // Offer one request and hold it until taken; valid stays high afterwards
    task automatic issue(ppes_pkg::t_op op, bit [2:0] lvl, bit [7:0] cb, bit [31:0] cb_arg,
                         bit [31:0] per, bit [31:0] runs, bit [31:0] now);
        ppes_pkg::t_req r;
        r.op           = op;
        r.level        = lvl;
        r.callback_id  = cb;
        r.callback_arg = cb_arg;
        r.period       = per;
        r.run_count    = runs;
        r.now          = now;
        req_if.valid        <= 1'b1;
        req_if.op           <= r.op;
        req_if.level        <= r.level;
        req_if.callback_id  <= r.callback_id;
        req_if.callback_arg <= r.callback_arg;
        req_if.period       <= r.period;
        req_if.run_count    <= r.run_count;
        req_if.now          <= r.now;
        do @(posedge i_clk); while (!req_if.ready);
        sched_sb.note_request(r);
    endtask

    // Sender pause until every expected response has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (sched_sb.expected_rsp.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int             pick;
        ppes_pkg::t_op  op;
        bit [2:0]       lvl;
        bit [7:0]       cb;
        bit [31:0]      cb_arg;
        bit [31:0]      per;
        bit [31:0]      runs;

        idle_pct     = 20;
        hold_off_req = 1'b0;
        tick_now     = 0;
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.op           <= ppes_pkg::OP_SCHED;
        req_if.level        <= '0;
        req_if.callback_id  <= '0;
        req_if.callback_arg <= '0;
        req_if.period       <= '0;
        req_if.run_count    <= '0;
        req_if.now          <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: disabled block, out-of-range levels, bad parameters
        issue(ppes_pkg::OP_SVC_ALL, 0, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
        issue(ppes_pkg::OP_SVC_ONE, 3, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
        issue(ppes_pkg::OP_SVC_ONE, 7, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(ppes_pkg::OP_SCHED, 4, 8'h01, 32'h1, 32'h1, 32'h1, 32'h0);
        issue(ppes_pkg::OP_SCHED, 0, 8'h00, 32'h1, 32'h5, 32'h1, 32'h0);
        issue(ppes_pkg::OP_SCHED, 0, 8'h09, 32'h1, 32'h0, 32'h1, 32'h0);
        // Extremes of the event fields; single-run event
        issue(ppes_pkg::OP_SCHED, 0, 8'hFF, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h0);
        // Enabled block, empty level
        issue(ppes_pkg::OP_SVC_ONE, 2, 8'h00, 32'h0, 32'h0, 32'h0, 32'd100);
        // Fill level 1: forever, two runs, huge count, three runs; then one more is full
        issue(ppes_pkg::OP_SCHED, 1, 8'h01, 32'h0000_0001, 32'd10, 32'd0, 32'h0);
        issue(ppes_pkg::OP_SCHED, 1, 8'h02, 32'h8000_0000, 32'd20, 32'd2, 32'h0);
        issue(ppes_pkg::OP_SCHED, 1, 8'h03, 32'h5A5A_5A5A, 32'd30, 32'hFFFF_FFFF, 32'h0);
        issue(ppes_pkg::OP_SCHED, 1, 8'h80, 32'hA5A5_A5A5, 32'd40, 32'd3, 32'h0);
        issue(ppes_pkg::OP_SCHED, 1, 8'h07, 32'h0, 32'd5, 32'd0, 32'h0);
        // Due time wraps past zero, so it is due at once
        issue(ppes_pkg::OP_SCHED, 2, 8'h55, 32'h1234_5678, 32'hFFFF_FFF0, 32'd1,
              32'h0000_0100);
        issue(ppes_pkg::OP_SVC_ONE, 1, 8'h00, 32'h0, 32'h0, 32'h0, 32'd20);
        issue(ppes_pkg::OP_SVC_ALL, 0, 8'h00, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        issue(ppes_pkg::OP_SVC_ONE, 1, 8'h00, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        // Freed slot is reused first
        issue(ppes_pkg::OP_SCHED, 1, 8'h11, 32'hDEAD_BEEF, 32'd7, 32'd2, 32'd50);
        issue(ppes_pkg::OP_SVC_ONE, 5, 8'h00, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        issue(ppes_pkg::OP_SCHED, 3, 8'h7F, 32'h0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        issue(ppes_pkg::OP_SVC_ALL, 0, 8'h00, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFE);
        issue(ppes_pkg::OP_CLEAR, 0, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
        issue(ppes_pkg::OP_SVC_ALL, 0, 8'h00, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        issue(ppes_pkg::OP_SCHED, 6, 8'h10, 32'h0, 32'h1, 32'h1, 32'h0);
        wait_drained();

        // Random: mostly well-formed traffic on a slowly advancing clock
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0 && i < RANDOM_ITEMS - QUIET_ITEMS) begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    2: idle_pct = 30;
                    default: idle_pct = 60;
                endcase
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS) idle_pct = 0;
            if (i == HOLD_AT) hold_off_req = 1'b1;

            if (i == DRAIN_AT) begin
                wait_drained();
            end else if ($urandom_range(0, 99) < idle_pct) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end

            tick_now = tick_now + $urandom_range(0, 12);
            if ($urandom_range(0, 49) == 0) tick_now = $urandom;
            cb     = 8'($urandom);
            cb_arg = $urandom;
            per    = $urandom;
            runs   = $urandom;
            lvl    = 3'($urandom_range(0, 7));
            pick   = $urandom_range(0, 99);
            if (pick < 45) begin
                op = ppes_pkg::OP_SCHED;
                if ($urandom_range(0, 19) != 0) lvl = 3'($urandom_range(0, LEVELS - 1));
                if ($urandom_range(0, 29) != 0) cb = 8'($urandom_range(1, 255));
                if ($urandom_range(0, 19) != 0) per = $urandom_range(1, 24);
                if ($urandom_range(0, 19) != 0) runs = $urandom_range(0, 4);
                if ($urandom_range(0, 29) == 0) per = 0;
            end else if (pick < 70) begin
                op = ppes_pkg::OP_SVC_ONE;
                if ($urandom_range(0, 9) != 0) lvl = 3'($urandom_range(0, LEVELS - 1));
            end else if (pick < 95) begin
                op = ppes_pkg::OP_SVC_ALL;
            end else begin
                op = ppes_pkg::OP_CLEAR;
            end
            issue(op, lvl, cb, cb_arg, per, runs, tick_now);
        end

        wait_drained();
        repeat (2 * TOTAL_SLOTS + 8) @(posedge i_clk);
        if (sched_sb.mismatches == 0 && sched_sb.expected_rsp.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
